>>> hw/rtl/unsorted_list_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unsorted list table unit
// Clocked property checks that disappear when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UNSORTED_LIST_TABLE_UNIT_MACROS_SVH
`define UNSORTED_LIST_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define ULT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ULT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ULT_ASSERT(lbl, prop, msg)
`define ULT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/ult_pkg.sv
// ----------------------------------------------------------------------------
// ult_pkg
// Sizes, status codes and shared types of the unsorted list table unit.
// ----------------------------------------------------------------------------
package ult_pkg;

    localparam int CAPACITY = 16;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [VALUE_W-1:0] wdata;
        logic [IDX_W-1:0]   raddr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } res_t;

endpackage

>>> hw/rtl/unsorted_list_table_unit.sv
// ----------------------------------------------------------------------------
// unsorted_list_table_unit
// Bounded unsorted table of signed values with swap-on-delete.
// ----------------------------------------------------------------------------
// One operation is taken at a time and answered by exactly one result beat.
// During a delete the entries below the count are compared one per cycle
// through the single read port of the entry memory, lowest index first, and
// a match costs one more read of the last entry before the swap write. A
// finished result waits in the output register, so the next input beat is
// taken while it is still stalled.
module unsorted_list_table_unit
    import ult_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic signed [VALUE_W-1:0]  value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic        [STATUS_W-1:0] status,
    output logic        [COUNT_W-1:0]  count,
    output logic                       full_res,
    output logic                       empty_res
);

    mem_req_t           mem_req;
    logic [VALUE_W-1:0] rdata;
    logic               res_ready;
    logic               res_valid;
    res_t               res;

    logic               out_valid_reg;
    res_t               out_res_reg;

    ult_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    ult_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign count     = out_res_reg.count;
    assign full_res  = (out_res_reg.count == COUNT_W'(CAPACITY));
    assign empty_res = (out_res_reg.count == '0);

endmodule

>>> hw/rtl/ult_mem.sv
// ----------------------------------------------------------------------------
// ult_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ult_mem
    import ult_pkg::*;
(
    input  logic               clk,
    input  mem_req_t           req,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] entries_reg [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            entries_reg[req.waddr] <= req.wdata;
        end
        rdata_reg <= entries_reg[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/ult_ctrl.sv
// ----------------------------------------------------------------------------
// ult_ctrl
// Operation sequencer: appends on insert, scans and swaps on delete.
// ----------------------------------------------------------------------------
`include "unsorted_list_table_unit_macros.svh"

module ult_ctrl
    import ult_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      op,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      res_ready,
    output logic                      res_valid,
    output res_t                      res,
    output mem_req_t                  mem_req,
    input  logic        [VALUE_W-1:0] rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]          state_reg,  state_next;
    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;
    logic [IDX_W-1:0]    hit_reg,    hit_next;
    logic [VALUE_W-1:0]  val_reg,    val_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [COUNT_W-1:0] count_dec;
    logic [IDX_W-1:0]   last_idx;
    logic               accept;

    assign count_dec = count_reg - COUNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        mem_req       = '0;
        res_valid     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next = $unsigned(value);
                    if (op == OP_INSERT)
                    begin
                        if (count_reg >= COUNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = count_reg[IDX_W-1:0];
                            mem_req.wdata = $unsigned(value);
                            count_next    = count_reg + COUNT_W'(1);
                            status_next   = ST_INSERTED;
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_MISSING;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        mem_req.raddr = '0;
                        idx_next      = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Read data here belongs to idx_reg; the next address is issued meanwhile.
                if (rdata == val_reg)
                begin
                    mem_req.raddr = last_idx;
                    hit_next      = idx_reg;
                    state_next    = S_MOVE;
                end
                else if (idx_reg == last_idx)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next      = idx_reg + IDX_W'(1);
                    mem_req.raddr = idx_reg + IDX_W'(1);
                end
            end

            S_MOVE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = hit_reg;
                mem_req.wdata = rdata;
                count_next    = count_dec;
                status_next   = ST_DELETED;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                res_valid = res_ready;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = '{status: status_reg, count: count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

    `ULT_ASSERT(a_count_bound, count_reg <= COUNT_W'(CAPACITY), "count above capacity")
    `ULT_ASSERT(a_scan_in_range, (state_reg == S_SCAN) |-> (COUNT_W'(idx_reg) < count_reg), "scan index past count")
    `ULT_ASSERT(a_move_drops_count, (state_reg == S_MOVE) |=> (count_reg == COUNT_W'($past(count_reg) - COUNT_W'(1))), "swap did not drop count")
    `ULT_ASSERT(a_write_state, mem_req.we |-> ((state_reg == S_IDLE) || (state_reg == S_MOVE)), "entry write outside insert or swap")

endmodule

>>> tb/unsorted_list_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsorted_list_table_checker
// Watches both channels of the unsorted list table unit, keeps its own copy
// of the table to work out the result of every accepted operation, and
// compares each result beat with the oldest outcome still waiting.
// ----------------------------------------------------------------------------
module unsorted_list_table_checker
    import ult_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       op,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic        [STATUS_W-1:0] status,
    input  logic        [COUNT_W-1:0]  count,
    input  logic                       full_res,
    input  logic                       empty_res,
    output int                         mismatches,
    output int                         awaiting
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                full;
        logic                empty;
    } outcome_t;

    logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
    int                        shadow_fill;
    outcome_t                  outcome_q [$];
    int                        errors;

    initial
    begin
        shadow_fill = 0;
        errors      = 0;
        mismatches  = 0;
        awaiting    = 0;
    end

    // Applies one operation to the shadow table and returns its outcome.
    function automatic outcome_t apply_op(logic o, logic signed [VALUE_W-1:0] v);
        outcome_t r;
        int       slot;
        slot = -1;
        if (o == OP_INSERT)
        begin
            if (shadow_fill >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                shadow_entries[shadow_fill] = v;
                shadow_fill                 = shadow_fill + 1;
                r.status                    = ST_INSERTED;
            end
        end
        else
        begin
            for (int i = 0; i < shadow_fill; i++)
            begin
                if (slot < 0 && shadow_entries[i] == v)
                begin
                    slot = i;
                end
            end
            if (slot >= 0)
            begin
                // The last held entry fills the hole, possibly onto itself.
                shadow_entries[slot] = shadow_entries[shadow_fill - 1];
                shadow_fill          = shadow_fill - 1;
                r.status             = ST_DELETED;
            end
            else
            begin
                r.status = ST_MISSING;
            end
        end
        r.count = COUNT_W'(shadow_fill);
        r.full  = (shadow_fill == CAPACITY);
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    task automatic report_mismatch(string why, outcome_t want, outcome_t got);
        errors = errors + 1;
        if (errors <= 40)
        begin
            $display("%0t ns: %s: expected status=%0d count=%0d full=%0b empty=%0b, got status=%0d count=%0d full=%0b empty=%0b",
                     $time, why, want.status, want.count, want.full, want.empty,
                     got.status, got.count, got.full, got.empty);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            shadow_fill = 0;
            outcome_q.delete();
        end
        else
        begin
            // A result beat never belongs to an operation taken at the same edge,
            // so the result side is settled first.
            if (out_valid && !out_stall)
            begin
                got = {status, count, full_res, empty_res};
                if (outcome_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing pending", '0, got);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status || got.count !== want.count ||
                        got.full !== want.full || got.empty !== want.empty)
                    begin
                        report_mismatch("wrong result", want, got);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                outcome_q.push_back(apply_op(op, value));
            end
        end
        awaiting   <= outcome_q.size();
        mismatches <= errors;
    end

endmodule

>>> tb/unsorted_list_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsorted_list_table_unit_tb
// Drives inserts and deletes into the unsorted list table unit with random
// gaps and result stalls, first a directed pass over fills, overflow,
// duplicates and swap deletes, then phases biased toward filling, churning or draining.
// ----------------------------------------------------------------------------
module unsorted_list_table_unit_tb
    import ult_pkg::*;
();

    localparam int RANDOM_OPS     = 1130;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_stall;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
    logic                      full_res;
    logic                      empty_res;

    int mismatches;
    int awaiting;
    int idle_cycles;
    int stall_left;
    bit sender_gaps;
    bit receiver_stalls;

    unsorted_list_table_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count),
        .full_res  (full_res),
        .empty_res (empty_res)
    );

    unsorted_list_table_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .count      (count),
        .full_res   (full_res),
        .empty_res  (empty_res),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left == 0 && receiver_stalls && $urandom_range(0, 99) < 35)
        begin
            stall_left = pick_gap() + 1;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("unsorted_list_table_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Presents one operation and returns at the edge that accepts its beat.
    task automatic send_op(logic o, logic signed [VALUE_W-1:0] v);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Holds the sender off until every pending result has come back.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic signed [VALUE_W-1:0] fill_vals [CAPACITY];
        logic signed [VALUE_W-1:0] pool [8];
        int                        sent;
        int                        phase_left;
        int                        insert_pct;
        int                        r;
        logic                      o;
        logic signed [VALUE_W-1:0] v;

        fill_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                      32'h8000_0000, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa,
                      32'hffff_ffff, 32'h0000_0001, 32'h7fff_fffe, 32'h8000_0001,
                      32'h0000_0000, 32'h1357_2468, 32'hdead_beef, 32'h2468_ace0};
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = OP_INSERT;
        value           = '0;
        out_stall       = 1'b0;
        stall_left      = 0;
        idle_cycles     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass: delete on an empty table, fill with extremes and
        // duplicates, overflow, then deletes that hit duplicates, the last
        // entry and values that are not held.
        send_op(OP_DELETE, 32'h0000_0000);
        for (int i = 0; i < CAPACITY; i++)
        begin
            send_op(OP_INSERT, fill_vals[i]);
        end
        send_op(OP_INSERT, 32'h1111_1111);
        send_op(OP_DELETE, 32'h3333_3333);
        send_op(OP_DELETE, 32'h8000_0000);
        send_op(OP_DELETE, 32'hdead_beef);
        send_op(OP_DELETE, 32'h7fff_ffff);
        send_op(OP_DELETE, 32'hffff_ffff);
        send_op(OP_INSERT, 32'h0000_1234);
        wait_results_drained();

        // Random phases, each biased toward filling, churning or draining, so
        // the table swings between full and empty.
        sent       = 0;
        phase_left = 0;
        insert_pct = 50;
        while (sent < RANDOM_OPS)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 80);
                r          = $urandom_range(0, 2);
                insert_pct = (r == 0) ? 80 : ((r == 1) ? 50 : 20);
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < 8; i++)
                begin
                    r = $urandom_range(0, 9);
                    if (r < 6)
                    begin
                        pool[i] = $urandom;
                    end
                    else if (r < 8)
                    begin
                        pool[i] = $urandom_range(0, 3);
                    end
                    else if (r == 8)
                    begin
                        pool[i] = 32'h8000_0000;
                    end
                    else
                    begin
                        pool[i] = 32'h7fff_ffff;
                    end
                end
            end
            if ($urandom_range(0, 99) == 0)
            begin
                wait_results_drained();
            end
            o = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            if ($urandom_range(0, 99) < 70)
            begin
                v = pool[$urandom_range(0, 7)];
            end
            else
            begin
                v = $urandom;
            end
            send_op(o, v);
            sent       = sent + 1;
            phase_left = phase_left - 1;
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("unsorted_list_table_unit_tb OK");
        end
        else
        begin
            $display("unsorted_list_table_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
